@@ rtl/iplpc_pkg.sv @@
package iplpc_pkg;

  localparam int TRIE_NODES_DEFAULT = 1024;

  // address walk
  localparam int ADDR_BITS = 32;
  localparam int STEP_W    = 6;
  localparam int LEN_W     = 6;

  // counter bank: index is class * 2 + direction
  localparam int CNT_W   = 64;
  localparam int NUM_CNT = 6;
  localparam int CIDX_W  = 3;
  localparam int WIRE_W  = 16;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 136;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam logic [1:0] CLASS_NATIONAL      = 2'd0;
  localparam logic [1:0] CLASS_INTERNATIONAL = 2'd1;
  localparam logic [1:0] CLASS_FOREIGN       = 2'd2;
  localparam logic [1:0] CLASS_UNUSED        = 2'd3;

  localparam logic [1:0] RDIR_OUT  = 2'd0;
  localparam logic [1:0] RDIR_IN   = 2'd1;
  localparam logic [1:0] RDIR_BOTH = 2'd2;

endpackage

@@ rtl/ip_locality_prefix_classifier.sv @@
// Classifies IPv4 packets as national, international or foreign against a binary
// trie of local prefixes held in one node RAM, and keeps 64-bit byte and packet
// counters per class and direction. The block takes one beat at a time and drops
// s_tready until that beat's result is loaded into the output register; the next
// beat is taken while the result still waits on m_tready. Every trie level costs
// a RAM read and then the loading of the node word, since the walk is bound
// by the single registered read port. An add walks prefix_length levels, ending
// early if memory runs out or the length is invalid. A classify makes two walks,
// source then destination, each ending early when a local node or a missing
// child is met, or at full depth. A read sums both directions
// through the shared 64-bit adder when both are asked for. No clearing pass is
// needed after reset: only the root lives in flip-flops.
module ip_locality_prefix_classifier #(
  parameter int TRIE_NODES = iplpc_pkg::TRIE_NODES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // prefix_value, prefix_length, source_addr, dest_addr, direction, wire_length,
  // read_class, read_direction, zero fill
  input  logic [iplpc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, traffic_class, byte_count, packet_count, zero fill
  output logic [iplpc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int NW = $clog2(TRIE_NODES);
  localparam int UW = $clog2(TRIE_NODES + 1);
  localparam int WW = 2 * NW + 1;
  localparam int CW = iplpc_pkg::CNT_W;

  typedef struct packed {
    logic          mark;
    logic [NW-1:0] one;
    logic [NW-1:0] zero;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_STEP,
    S_ADD_LOAD,
    S_ADD_NEW,
    S_LK_STEP,
    S_LK_LOAD,
    S_CNT_B,
    S_CNT_P,
    S_RD_LOAD,
    S_RD_SUMB,
    S_RD_SUMP,
    S_FINISH
  } state_t;

  // input unpack
  logic [31:0]                     in_prefix_value;
  logic [iplpc_pkg::LEN_W-1:0]     in_prefix_length;
  logic [31:0]                     in_source_addr;
  logic [31:0]                     in_dest_addr;
  logic                            in_direction;
  logic [iplpc_pkg::WIRE_W-1:0]    in_wire_length;
  logic [1:0]                      in_read_class;
  logic [1:0]                      in_read_direction;

  assign in_prefix_value   = s_tdata[31:0];
  assign in_prefix_length  = s_tdata[37:32];
  assign in_source_addr    = s_tdata[69:38];
  assign in_dest_addr      = s_tdata[101:70];
  assign in_direction      = s_tdata[102];
  assign in_wire_length    = s_tdata[118:103];
  assign in_read_class     = s_tdata[120:119];
  assign in_read_direction = s_tdata[122:121];

  state_t                          state;
  node_t                           root;
  node_t                           cur;
  logic [NW-1:0]                   pos;
  logic [UW-1:0]                   nodes_used;
  logic [31:0]                     path;
  logic [31:0]                     dst_q;
  logic [iplpc_pkg::STEP_W-1:0]    step;
  logic [iplpc_pkg::LEN_W-1:0]     len_q;
  logic                            lk_second;
  logic                            src_local;
  logic                            dir_q;
  logic [iplpc_pkg::WIRE_W-1:0]    wire_q;
  logic                            rd_sum;
  logic [iplpc_pkg::CIDX_W-1:0]    cidx;
  logic [CW-1:0]                   byte_cnt [iplpc_pkg::NUM_CNT];
  logic [CW-1:0]                   pkt_cnt  [iplpc_pkg::NUM_CNT];

  logic [1:0]                      res_status;
  logic [1:0]                      res_class;
  logic [CW-1:0]                   res_bytes;
  logic [CW-1:0]                   res_pkts;
  logic [1:0]                      out_status;
  logic [1:0]                      out_class;
  logic [CW-1:0]                   out_bytes;
  logic [CW-1:0]                   out_pkts;

  // walk datapath
  logic                            bit_now;
  logic [NW-1:0]                   child;
  logic                            trie_full;
  logic                            add_done;
  logic                            lk_hit;
  logic                            lk_end;
  logic [NW-1:0]                   new_node;
  node_t                           linked;
  node_t                           marked;
  node_t                           rd_node;
  logic                            found;
  logic [1:0]                      pkt_class;

  logic                            ram_wr_en;
  logic [NW-1:0]                   ram_wr_addr;
  logic [WW-1:0]                   ram_wr_data;
  logic                            ram_rd_en;
  logic [WW-1:0]                   ram_rd_data;

  // shared 64-bit adder
  logic [CW-1:0]                   add_a;
  logic [CW-1:0]                   add_b;
  logic [CW-1:0]                   add_sum;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {4'b0, out_pkts, out_bytes, out_class, out_status};

  assign bit_now   = path[31];
  assign child     = bit_now ? cur.one : cur.zero;
  assign trie_full = (nodes_used == UW'(TRIE_NODES));
  assign add_done  = (step == len_q);
  assign new_node  = nodes_used[NW-1:0];
  assign rd_node   = node_t'(ram_rd_data);
  assign lk_hit    = cur.mark;
  assign lk_end    = lk_hit || (step == iplpc_pkg::STEP_W'(iplpc_pkg::ADDR_BITS))
                     || (child == '0);
  assign found     = lk_hit;

  always_comb begin
    linked = cur;
    if (bit_now) begin
      linked.one = new_node;
    end else begin
      linked.zero = new_node;
    end
    marked = cur;
    marked.mark = 1'b1;
  end

  always_comb begin
    if (src_local && found) begin
      pkt_class = iplpc_pkg::CLASS_NATIONAL;
    end else if (!src_local && !found) begin
      pkt_class = iplpc_pkg::CLASS_FOREIGN;
    end else begin
      pkt_class = iplpc_pkg::CLASS_INTERNATIONAL;
    end
  end

  // root links live in flip-flops, so node ram writes only touch nodes 1 and up
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos;
    ram_wr_data = WW'(linked);
    if (state == S_ADD_STEP && pos != '0) begin
      if (add_done) begin
        ram_wr_en   = 1'b1;
        ram_wr_data = WW'(marked);
      end else if (child == '0 && !trie_full) begin
        ram_wr_en = 1'b1;
      end
    end else if (state == S_ADD_NEW) begin
      ram_wr_en   = 1'b1;
      ram_wr_data = '0;
    end
  end

  assign ram_rd_en = (state == S_ADD_STEP) || (state == S_LK_STEP);

  iplpc_ram #(
    .WIDTH (WW),
    .DEPTH (TRIE_NODES)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (child),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    unique case (state)
      S_CNT_B: begin
        add_a = byte_cnt[cidx];
        add_b = CW'(wire_q);
      end
      S_CNT_P: begin
        add_a = pkt_cnt[cidx];
        add_b = CW'(1);
      end
      S_RD_SUMB: begin
        add_a = res_bytes;
        add_b = byte_cnt[cidx];
      end
      S_RD_SUMP: begin
        add_a = res_pkts;
        add_b = pkt_cnt[cidx];
      end
      default: begin
        add_a = res_bytes;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      nodes_used <= UW'(1);
      root       <= '0;
      for (int i = 0; i < iplpc_pkg::NUM_CNT; i++) begin
        byte_cnt[i] <= '0;
        pkt_cnt[i]  <= '0;
      end
    end else begin
      if (state == S_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_status <= iplpc_pkg::STATUS_OK;
            res_class  <= iplpc_pkg::CLASS_NATIONAL;
            res_bytes  <= '0;
            res_pkts   <= '0;
            step       <= '0;
            pos        <= '0;
            cur        <= root;
            lk_second  <= 1'b0;
            dir_q      <= in_direction;
            wire_q     <= in_wire_length;
            dst_q      <= in_dest_addr;
            len_q      <= in_prefix_length;
            rd_sum     <= (in_read_direction == iplpc_pkg::RDIR_BOTH);
            cidx       <= {in_read_class, in_read_direction == iplpc_pkg::RDIR_IN};
            unique case (s_tuser)
              iplpc_pkg::OP_ADD: begin
                path <= in_prefix_value;
                if (in_prefix_length > iplpc_pkg::LEN_W'(iplpc_pkg::ADDR_BITS)) begin
                  res_status <= iplpc_pkg::STATUS_BAD_LEN;
                  state      <= S_FINISH;
                end else begin
                  state <= S_ADD_STEP;
                end
              end
              iplpc_pkg::OP_CLASSIFY: begin
                path  <= in_source_addr;
                state <= S_LK_STEP;
              end
              iplpc_pkg::OP_READ: begin
                res_class <= in_read_class;
                if (in_read_class == iplpc_pkg::CLASS_UNUSED ||
                    in_read_direction > iplpc_pkg::RDIR_BOTH) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_RD_LOAD;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_ADD_STEP: begin
          if (add_done) begin
            if (pos == '0) begin
              root.mark <= 1'b1;
            end
            state <= S_FINISH;
          end else if (child != '0) begin
            pos   <= child;
            path  <= path << 1;
            step  <= step + 1'b1;
            state <= S_ADD_LOAD;
          end else if (trie_full) begin
            res_status <= iplpc_pkg::STATUS_FULL;
            state      <= S_FINISH;
          end else begin
            // parent link goes out this cycle, the fresh node is cleared next
            if (pos == '0) begin
              root <= linked;
            end
            nodes_used <= nodes_used + UW'(1);
            pos        <= new_node;
            cur        <= '0;
            path       <= path << 1;
            step       <= step + 1'b1;
            state      <= S_ADD_NEW;
          end
        end

        S_ADD_LOAD: begin
          cur   <= rd_node;
          state <= S_ADD_STEP;
        end

        S_ADD_NEW: begin
          state <= S_ADD_STEP;
        end

        S_LK_STEP: begin
          if (lk_end) begin
            if (!lk_second) begin
              src_local <= found;
              lk_second <= 1'b1;
              path      <= dst_q;
              step      <= '0;
              cur       <= root;
            end else begin
              res_class <= pkt_class;
              cidx      <= {pkt_class, dir_q};
              state     <= S_CNT_B;
            end
          end else begin
            path  <= path << 1;
            step  <= step + 1'b1;
            state <= S_LK_LOAD;
          end
        end

        S_LK_LOAD: begin
          cur   <= rd_node;
          state <= S_LK_STEP;
        end

        S_CNT_B: begin
          byte_cnt[cidx] <= add_sum;
          res_bytes      <= add_sum;
          state          <= S_CNT_P;
        end

        S_CNT_P: begin
          pkt_cnt[cidx] <= add_sum;
          res_pkts      <= add_sum;
          state         <= S_FINISH;
        end

        S_RD_LOAD: begin
          res_bytes <= byte_cnt[cidx];
          res_pkts  <= pkt_cnt[cidx];
          if (rd_sum) begin
            cidx  <= cidx + 1'b1;
            state <= S_RD_SUMB;
          end else begin
            state <= S_FINISH;
          end
        end

        S_RD_SUMB: begin
          res_bytes <= add_sum;
          state     <= S_RD_SUMP;
        end

        S_RD_SUMP: begin
          res_pkts <= add_sum;
          state    <= S_FINISH;
        end

        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            out_status <= res_status;
            out_class  <= res_class;
            out_bytes  <= res_bytes;
            out_pkts   <= res_pkts;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/iplpc_ram.sv @@
module iplpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/iplpc_checker.sv @@
module iplpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [iplpc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic s_beat;

  assign s_beat = s_tvalid && s_tready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // block is busy in the cycle after it takes a beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_beat |=> !s_tready && !$rose(m_tvalid))
    else $error("block ready or result shown right after input beat");

  // an error status only comes from an add, which carries no counts
  a_err_no_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != iplpc_pkg::STATUS_OK) |->
      (m_tdata[3:2] == iplpc_pkg::CLASS_NATIONAL) && (m_tdata[131:4] == '0))
    else $error("error status with nonzero class or counts");

  // the unused class only appears on a read and reads as zero
  a_unused_class_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:2] == iplpc_pkg::CLASS_UNUSED) |->
      (m_tdata[1:0] == iplpc_pkg::STATUS_OK) && (m_tdata[131:4] == '0))
    else $error("unused class returned nonzero counts");

endmodule

bind ip_locality_prefix_classifier iplpc_checker u_iplpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ verif/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = iplpc_pkg::TRIE_NODES_DEFAULT;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] RDIR_UNUSED = 2'd3;
  localparam int HOLD_LEN = 600;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] pfx;
    logic [5:0]  plen;
    logic [31:0] src;
    logic [31:0] dst;
    logic        dir;
    logic [15:0] wlen;
    logic [1:0]  rcls;
    logic [1:0]  rdir;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  tclass;
    logic [63:0] bytes;
    logic [63:0] pkts;
  } outcome_t;

  typedef struct {
    logic [31:0] value;
    int          len;
  } net_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [iplpc_pkg::IN_TDATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [iplpc_pkg::OUT_TDATA_W-1:0] m_tdata;

  ip_locality_prefix_classifier DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow trie and traffic counters
  int          zero_link [NODES];
  int          one_link [NODES];
  bit          marked [NODES];
  int          nodes_alloc;
  logic [63:0] bytes_tally [6];
  logic [63:0] pkts_tally [6];

  outcome_t pending_outcomes[$];
  net_t     local_nets[$];

  bit idle_on;
  int hold_requests;
  int hold_served;
  int mismatches;
  int results_seen;
  int n_add, n_add_bad, n_add_full, n_pkt, n_read, n_unused;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] net_mask(int len);
    return (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
  endfunction

  function automatic bit addr_is_local(logic [31:0] a);
    int pos;
    int nxt;
    pos = 0;
    for (int b = 31; b >= 0; b--) begin
      if (marked[pos]) return 1'b1;
      nxt = a[b] ? one_link[pos] : zero_link[pos];
      if (nxt == 0) return 1'b0;
      pos = nxt;
    end
    return marked[pos];
  endfunction

  function automatic logic [1:0] trie_insert(logic [31:0] value, int len);
    int pos;
    int nxt;
    pos = 0;
    if (len > 32) return iplpc_pkg::STATUS_BAD_LEN;
    for (int i = 0; i < len; i++) begin
      nxt = value[31-i] ? one_link[pos] : zero_link[pos];
      if (nxt == 0) begin
        // links made so far stay in place, unmarked
        if (nodes_alloc >= NODES) return iplpc_pkg::STATUS_FULL;
        nxt = nodes_alloc;
        nodes_alloc++;
        zero_link[nxt] = 0;
        one_link[nxt] = 0;
        marked[nxt] = 1'b0;
        if (value[31-i]) one_link[pos] = nxt;
        else zero_link[pos] = nxt;
      end
      pos = nxt;
    end
    marked[pos] = 1'b1;
    return iplpc_pkg::STATUS_OK;
  endfunction

  function automatic outcome_t locality_outcome(item_t it);
    outcome_t o;
    bit s_loc;
    bit d_loc;
    int idx;
    o = '0;
    case (it.op)
      iplpc_pkg::OP_ADD: o.status = trie_insert(it.pfx, int'(it.plen));
      iplpc_pkg::OP_CLASSIFY: begin
        s_loc = addr_is_local(it.src);
        d_loc = addr_is_local(it.dst);
        if (s_loc && d_loc) o.tclass = iplpc_pkg::CLASS_NATIONAL;
        else if (!s_loc && !d_loc) o.tclass = iplpc_pkg::CLASS_FOREIGN;
        else o.tclass = iplpc_pkg::CLASS_INTERNATIONAL;
        idx = int'(o.tclass) * 2 + int'(it.dir);
        bytes_tally[idx] = bytes_tally[idx] + 64'(it.wlen);
        pkts_tally[idx] = pkts_tally[idx] + 64'd1;
        o.bytes = bytes_tally[idx];
        o.pkts = pkts_tally[idx];
      end
      iplpc_pkg::OP_READ: begin
        o.tclass = it.rcls;
        if (it.rcls != iplpc_pkg::CLASS_UNUSED) begin
          idx = int'(it.rcls) * 2;
          if (it.rdir == iplpc_pkg::RDIR_OUT || it.rdir == iplpc_pkg::RDIR_IN) begin
            o.bytes = bytes_tally[idx + int'(it.rdir)];
            o.pkts = pkts_tally[idx + int'(it.rdir)];
          end else if (it.rdir == iplpc_pkg::RDIR_BOTH) begin
            o.bytes = bytes_tally[idx] + bytes_tally[idx + 1];
            o.pkts = pkts_tally[idx] + pkts_tally[idx + 1];
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic item_t random_fill(logic [1:0] op);
    item_t it;
    it.op = op;
    it.pfx = $urandom;
    it.plen = 6'($urandom);
    it.src = $urandom;
    it.dst = $urandom;
    it.dir = 1'($urandom);
    it.wlen = 16'($urandom);
    it.rcls = 2'($urandom);
    it.rdir = 2'($urandom);
    return it;
  endfunction

  function automatic item_t mk_add(logic [31:0] value, int len);
    item_t it;
    it = random_fill(iplpc_pkg::OP_ADD);
    it.pfx = value;
    it.plen = 6'(len);
    return it;
  endfunction

  function automatic item_t mk_pkt(logic [31:0] src, logic [31:0] dst, logic dir,
                                   logic [15:0] wlen);
    item_t it;
    it = random_fill(iplpc_pkg::OP_CLASSIFY);
    it.src = src;
    it.dst = dst;
    it.dir = dir;
    it.wlen = wlen;
    return it;
  endfunction

  function automatic item_t mk_read(logic [1:0] rcls, logic [1:0] rdir);
    item_t it;
    it = random_fill(iplpc_pkg::OP_READ);
    it.rcls = rcls;
    it.rdir = rdir;
    return it;
  endfunction

  // address inside a known local net, just outside it, or anywhere
  function automatic logic [31:0] pick_addr();
    net_t n;
    logic [31:0] a;
    int r;
    r = $urandom_range(99);
    if (local_nets.size() == 0 || r < 40) return $urandom;
    n = local_nets[$urandom_range(local_nets.size() - 1)];
    a = (n.value & net_mask(n.len)) | ($urandom & ~net_mask(n.len));
    if (r < 55 && n.len > 0) a = a ^ (32'h1 << (32 - n.len));
    return a;
  endfunction

  task automatic send_item(input item_t it);
    outcome_t o;
    if (idle_on && $urandom_range(99) < 8) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {5'b0, it.rdir, it.rcls, it.wlen, it.dir, it.dst, it.src, it.plen, it.pfx};
    do @(posedge clk); while (!s_tready);
    o = locality_outcome(it);
    pending_outcomes.push_back(o);
    case (it.op)
      iplpc_pkg::OP_ADD: begin
        n_add++;
        if (o.status == iplpc_pkg::STATUS_BAD_LEN) n_add_bad++;
        if (o.status == iplpc_pkg::STATUS_FULL) n_add_full++;
        if (o.status == iplpc_pkg::STATUS_OK) local_nets.push_back('{it.pfx, int'(it.plen)});
      end
      iplpc_pkg::OP_CLASSIFY: n_pkt++;
      iplpc_pkg::OP_READ: n_read++;
      default: n_unused++;
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        m_tready <= 1'b0;
        for (int c = 1; c < HOLD_LEN; c++) @(negedge clk);
      end else begin
        m_tready <= !(idle_on && $urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.tclass = m_tdata[3:2];
      got.bytes = m_tdata[67:4];
      got.pkts = m_tdata[131:68];
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected beat", '0, got.bytes);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status != want.status) flag_mismatch("status", want.status, got.status);
        if (got.tclass != want.tclass) flag_mismatch("traffic_class", want.tclass, got.tclass);
        if (got.bytes != want.bytes) flag_mismatch("byte_count", want.bytes, got.bytes);
        if (got.pkts != want.pkts) flag_mismatch("packet_count", want.pkts, got.pkts);
      end
    end
  end

  task automatic test_directed();
    send_item(mk_add(32'h0A00_0000, 8));
    send_item(mk_add(32'hC0A8_0000, 16));
    send_item(mk_add(32'hFFFF_FFFF, 32));
    send_item(mk_add(32'h0000_0000, 32));
    send_item(mk_add(32'h1234_5678, 33));
    send_item(mk_add(32'hFFFF_FFFF, 63));
    send_item(mk_pkt(32'h0A01_0203, 32'hC0A8_0505, 1'b0, 16'h0000));
    send_item(mk_pkt(32'h0A01_0203, 32'h0808_0808, 1'b1, 16'hFFFF));
    send_item(mk_pkt(32'h0808_0808, 32'h0AFF_FFFF, 1'b0, 16'd1500));
    send_item(mk_pkt(32'h0102_0304, 32'h7F00_0001, 1'b1, 16'd64));
    send_item(mk_pkt(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 16'hFFFF));
    // walks through allocated but unmarked nodes
    send_item(mk_pkt(32'hFFFF_FFFE, 32'h0000_0001, 1'b0, 16'd40));
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_INTERNATIONAL, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_FOREIGN, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_INTERNATIONAL, iplpc_pkg::RDIR_OUT));
    send_item(mk_read(iplpc_pkg::CLASS_FOREIGN, iplpc_pkg::RDIR_IN));
    send_item(mk_read(iplpc_pkg::CLASS_UNUSED, iplpc_pkg::RDIR_OUT));
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, RDIR_UNUSED));
    send_item(random_fill(OP_UNUSED));
  endtask

  task automatic test_random_mix();
    item_t it;
    net_t base;
    int r;
    int len;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 300 && n < 500);
      r = $urandom_range(99);
      if (r < 6) begin
        if ($urandom_range(19) == 0) begin
          it = mk_add($urandom, $urandom_range(63, 33));
        end else if (local_nets.size() != 0 && $urandom_range(1)) begin
          // grow a longer prefix under a known one
          base = local_nets[$urandom_range(local_nets.size() - 1)];
          len = base.len + $urandom_range(8, 1);
          if (len > 32) len = 32;
          it = mk_add((base.value & net_mask(base.len)) | ($urandom & ~net_mask(base.len)), len);
        end else begin
          it = mk_add($urandom, $urandom_range(24, 8));
        end
      end else if (r < 76) begin
        it = mk_pkt(pick_addr(), pick_addr(), 1'($urandom), 16'($urandom));
      end else if (r < 94) begin
        it = random_fill(iplpc_pkg::OP_READ);
      end else begin
        it = random_fill(OP_UNUSED);
      end
      send_item(it);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_requests++;
    idle_on = 1'b0;
    for (int n = 0; n < 30; n++)
      send_item(mk_pkt(pick_addr(), pick_addr(), 1'($urandom), 16'($urandom)));
    idle_on = 1'b1;
  endtask

  task automatic test_node_exhaustion();
    logic [31:0] a;
    net_t n;
    for (int i = 0; i < 200 && nodes_alloc < NODES; i++) begin
      a = $urandom;
      send_item(mk_add(a, 32));
      send_item(mk_pkt(a, $urandom, 1'($urandom), 16'($urandom)));
    end
    for (int i = 0; i < 8; i++) begin
      a = $urandom;
      send_item(mk_add(a, 32));
      // a host whose add ran out of nodes is not made local by that add
      send_item(mk_pkt(a, a ^ 32'h1, 1'($urandom), 16'($urandom)));
      n = local_nets[$urandom_range(local_nets.size() - 1)];
      send_item(mk_add(n.value, n.len));
    end
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_FOREIGN, iplpc_pkg::RDIR_BOTH));
  endtask

  task automatic test_root_prefix();
    send_item(mk_add($urandom, 0));
    for (int n = 0; n < 25; n++)
      send_item(mk_pkt($urandom, $urandom, 1'($urandom), 16'($urandom)));
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, iplpc_pkg::RDIR_OUT));
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, iplpc_pkg::RDIR_IN));
    send_item(mk_read(iplpc_pkg::CLASS_NATIONAL, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_INTERNATIONAL, iplpc_pkg::RDIR_BOTH));
    send_item(mk_read(iplpc_pkg::CLASS_FOREIGN, iplpc_pkg::RDIR_BOTH));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = iplpc_pkg::OP_ADD;
    idle_on = 1'b1;
    hold_requests = 0;
    hold_served = 0;
    mismatches = 0;
    results_seen = 0;
    {n_add, n_add_bad, n_add_full, n_pkt, n_read, n_unused} = '0;
    for (int i = 0; i < NODES; i++) begin
      zero_link[i] = 0;
      one_link[i] = 0;
      marked[i] = 1'b0;
    end
    nodes_alloc = 1;
    for (int i = 0; i < 6; i++) begin
      bytes_tally[i] = '0;
      pkts_tally[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix();
    test_backpressure();
    test_node_exhaustion();
    test_root_prefix();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d adds (%0d bad length, %0d out of nodes), %0d packets, %0d reads,",
             n_add, n_add_bad, n_add_full, n_pkt, n_read);
    $display("%0d unused ops; %0d result beats checked, trie nodes in use %0d of %0d",
             n_unused, results_seen, nodes_alloc, NODES);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/iplpc_pkg.sv
rtl/iplpc_ram.sv
rtl/ip_locality_prefix_classifier.sv
rtl/iplpc_checker.sv
verif/tb.sv
